FILE: design/i2cbr_pkg.sv
package i2cbr_pkg;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned DelayW = 9;
  localparam int unsigned WaitW  = 17;
  localparam int unsigned PulseW = 4;
  localparam int unsigned HalfW  = 8;
  localparam int unsigned ToutW  = 16;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PhaseW-1:0] PH_IDLE      = 4'd0;
  localparam logic [PhaseW-1:0] PH_SETTLE    = 4'd1;
  localparam logic [PhaseW-1:0] PH_INIT_WAIT = 4'd2;
  localparam logic [PhaseW-1:0] PH_PRE_WAIT  = 4'd3;
  localparam logic [PhaseW-1:0] PH_LOW       = 4'd4;
  localparam logic [PhaseW-1:0] PH_HIGH_WAIT = 4'd5;
  localparam logic [PhaseW-1:0] PH_HIGH      = 4'd6;
  localparam logic [PhaseW-1:0] PH_STOP_A    = 4'd7;
  localparam logic [PhaseW-1:0] PH_STOP_B    = 4'd8;
  localparam logic [PhaseW-1:0] PH_STOP_WAIT = 4'd9;
  localparam logic [PhaseW-1:0] PH_STOP_C    = 4'd10;
  localparam logic [PhaseW-1:0] PH_STOP_D    = 4'd11;
  localparam logic [PhaseW-1:0] PH_FINAL     = 4'd12;

  localparam logic [CfgIdxW-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STRETCH_TO  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PULSE_COUNT = 2'd2;

  localparam logic [HalfW-1:0]  HALF_RESET   = 8'd10 >> 1;
  localparam logic [ToutW-1:0]  TOUT_RESET   = 16'd500;
  localparam logic [PulseW-1:0] PULSES_RESET = 4'd9;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic ERR_NONE    = 1'b0;
  localparam logic ERR_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [HalfW-1:0]  half_period;
    logic [ToutW-1:0]  stretch_timeout;
    logic [PulseW-1:0] pulse_count;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [DelayW-1:0] delay_left;
    logic [WaitW-1:0]  stretch_waited;
    logic [PulseW-1:0] pulse_index;
    logic              scl_drv;
    logic              sda_drv;
    logic              rec_scl;
    logic              rec_sda;
    logic              ok_flag;
    logic              err;
    logic [CntW-1:0]   ok_cnt;
    logic [CntW-1:0]   fail_cnt;
  } state_t;

endpackage

FILE: design/i2cbr_if.sv
interface i2cbr_in_if;
  logic valid;
  logic ready;
  logic op;
  logic scl_in;
  logic sda_in;

  modport source (output valid, output op, output scl_in, output sda_in, input ready);
  modport sink (input valid, input op, input scl_in, input sda_in, output ready);
endinterface

interface i2cbr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          scl_release;
  logic                          sda_release;
  logic                          busy_res;
  logic                          done_res;
  logic                          success;
  logic                          seen_scl;
  logic                          seen_sda;
  logic                          timeout_err;
  logic [i2cbr_pkg::CntW-1:0]    recover_total;
  logic [i2cbr_pkg::CntW-1:0]    fail_total;

  modport source (output valid, output scl_release, output sda_release, output busy_res,
                  output done_res, output success, output seen_scl, output seen_sda,
                  output timeout_err, output recover_total, output fail_total,
                  input ready);
  modport sink (input valid, input scl_release, input sda_release, input busy_res,
                input done_res, input success, input seen_scl, input seen_sda,
                input timeout_err, input recover_total, input fail_total,
                output ready);
endinterface

interface i2cbr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [i2cbr_pkg::CfgIdxW-1:0]   index;
  logic [i2cbr_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/i2cbr_step.sv
module i2cbr_step (
  input  i2cbr_pkg::state_t cur_i,
  input  i2cbr_pkg::cfg_t   cfg_i,
  input  logic              op_i,
  input  logic              scl_i,
  input  logic              sda_i,
  output i2cbr_pkg::state_t nxt_o,
  output logic              done_o
);

  logic [i2cbr_pkg::HalfW-1:0]  half;
  logic [i2cbr_pkg::DelayW-1:0] per;
  logic [i2cbr_pkg::DelayW-1:0] dec;
  logic [i2cbr_pkg::WaitW-1:0]  wait_add;
  logic                         to_cur;
  logic                         to_zero;
  logic                         more_pulses;
  logic [i2cbr_pkg::PulseW-1:0] pi_inc;

  assign half     = (cfg_i.half_period == '0) ? i2cbr_pkg::HalfW'(1) : cfg_i.half_period;
  assign per      = {half, 1'b0};
  assign dec      = (cur_i.delay_left != '0) ? cur_i.delay_left - 1'b1 : cur_i.delay_left;
  assign wait_add = cur_i.stretch_waited + {{(i2cbr_pkg::WaitW-i2cbr_pkg::DelayW){1'b0}}, per};
  assign to_cur   = cur_i.stretch_waited >= {1'b0, cfg_i.stretch_timeout};
  assign to_zero  = cfg_i.stretch_timeout == '0;
  assign pi_inc   = cur_i.pulse_index + 1'b1;
  assign more_pulses = cur_i.pulse_index < cfg_i.pulse_count;

  always_comb begin
    nxt_o  = cur_i;
    done_o = 1'b0;
    if (op_i == i2cbr_pkg::OP_START) begin
      if (cur_i.phase == i2cbr_pkg::PH_IDLE) begin
        nxt_o.scl_drv        = 1'b1;
        nxt_o.sda_drv        = 1'b1;
        nxt_o.stretch_waited = '0;
        nxt_o.pulse_index    = '0;
        nxt_o.phase          = i2cbr_pkg::PH_SETTLE;
        nxt_o.delay_left     = per;
      end
    end else if (cur_i.phase != i2cbr_pkg::PH_IDLE) begin
      nxt_o.delay_left = dec;
      if (dec == '0) begin
        case (cur_i.phase)
          i2cbr_pkg::PH_SETTLE, i2cbr_pkg::PH_INIT_WAIT: begin
            if (cur_i.phase == i2cbr_pkg::PH_SETTLE) begin
              nxt_o.rec_scl = scl_i;
              nxt_o.rec_sda = sda_i;
            end
            if (scl_i) begin
              nxt_o.stretch_waited = '0;
              if (!more_pulses) begin
                nxt_o.scl_drv    = 1'b0;
                nxt_o.phase      = i2cbr_pkg::PH_STOP_A;
                nxt_o.delay_left = {1'b0, half};
              end else begin
                nxt_o.scl_drv    = 1'b0;
                nxt_o.phase      = i2cbr_pkg::PH_LOW;
                nxt_o.delay_left = {1'b0, half};
              end
            end else if ((cur_i.phase == i2cbr_pkg::PH_SETTLE) ? to_zero : to_cur) begin
              done_o         = 1'b1;
              nxt_o.fail_cnt = cur_i.fail_cnt + 1'b1;
              nxt_o.ok_flag  = 1'b0;
              nxt_o.err      = i2cbr_pkg::ERR_TIMEOUT;
              nxt_o.phase    = i2cbr_pkg::PH_IDLE;
              nxt_o.delay_left = '0;
              nxt_o.scl_drv  = 1'b1;
              nxt_o.sda_drv  = 1'b1;
            end else begin
              nxt_o.phase          = i2cbr_pkg::PH_INIT_WAIT;
              nxt_o.stretch_waited = (cur_i.phase == i2cbr_pkg::PH_SETTLE) ?
                                     {{(i2cbr_pkg::WaitW-i2cbr_pkg::DelayW){1'b0}}, per} :
                                     wait_add;
              nxt_o.delay_left     = per;
            end
          end
          i2cbr_pkg::PH_PRE_WAIT, i2cbr_pkg::PH_HIGH_WAIT: begin
            if (scl_i) begin
              if (cur_i.phase == i2cbr_pkg::PH_PRE_WAIT) begin
                nxt_o.scl_drv = 1'b0;
                nxt_o.phase   = i2cbr_pkg::PH_LOW;
              end else begin
                nxt_o.phase   = i2cbr_pkg::PH_HIGH;
              end
              nxt_o.delay_left = {1'b0, half};
            end else if (to_cur) begin
              nxt_o.scl_drv    = 1'b0;
              nxt_o.phase      = i2cbr_pkg::PH_STOP_A;
              nxt_o.delay_left = {1'b0, half};
            end else begin
              nxt_o.stretch_waited = wait_add;
              nxt_o.delay_left     = per;
            end
          end
          i2cbr_pkg::PH_LOW: begin
            nxt_o.scl_drv        = 1'b1;
            nxt_o.stretch_waited = '0;
            nxt_o.phase          = i2cbr_pkg::PH_HIGH_WAIT;
            nxt_o.delay_left     = i2cbr_pkg::DelayW'(1);
          end
          i2cbr_pkg::PH_HIGH: begin
            nxt_o.pulse_index = pi_inc;
            if (pi_inc >= cfg_i.pulse_count) begin
              nxt_o.scl_drv    = 1'b0;
              nxt_o.phase      = i2cbr_pkg::PH_STOP_A;
              nxt_o.delay_left = {1'b0, half};
            end else begin
              nxt_o.stretch_waited = '0;
              if (scl_i) begin
                nxt_o.scl_drv    = 1'b0;
                nxt_o.phase      = i2cbr_pkg::PH_LOW;
                nxt_o.delay_left = {1'b0, half};
              end else if (to_zero) begin
                nxt_o.scl_drv    = 1'b0;
                nxt_o.phase      = i2cbr_pkg::PH_STOP_A;
                nxt_o.delay_left = {1'b0, half};
              end else begin
                nxt_o.phase          = i2cbr_pkg::PH_PRE_WAIT;
                nxt_o.stretch_waited =
                  {{(i2cbr_pkg::WaitW-i2cbr_pkg::DelayW){1'b0}}, per};
                nxt_o.delay_left     = per;
              end
            end
          end
          i2cbr_pkg::PH_STOP_A: begin
            nxt_o.sda_drv    = 1'b0;
            nxt_o.phase      = i2cbr_pkg::PH_STOP_B;
            nxt_o.delay_left = {1'b0, half};
          end
          i2cbr_pkg::PH_STOP_B: begin
            nxt_o.scl_drv        = 1'b1;
            nxt_o.stretch_waited = '0;
            nxt_o.phase          = i2cbr_pkg::PH_STOP_WAIT;
            nxt_o.delay_left     = i2cbr_pkg::DelayW'(1);
          end
          i2cbr_pkg::PH_STOP_WAIT: begin
            if (scl_i || to_cur) begin
              nxt_o.phase      = i2cbr_pkg::PH_STOP_C;
              nxt_o.delay_left = {1'b0, half};
            end else begin
              nxt_o.stretch_waited = wait_add;
              nxt_o.delay_left     = per;
            end
          end
          i2cbr_pkg::PH_STOP_C: begin
            nxt_o.sda_drv    = 1'b1;
            nxt_o.phase      = i2cbr_pkg::PH_STOP_D;
            nxt_o.delay_left = {1'b0, half};
          end
          i2cbr_pkg::PH_STOP_D: begin
            nxt_o.phase      = i2cbr_pkg::PH_FINAL;
            nxt_o.delay_left = per;
          end
          i2cbr_pkg::PH_FINAL: begin
            done_o           = 1'b1;
            nxt_o.rec_scl    = scl_i;
            nxt_o.rec_sda    = sda_i;
            nxt_o.phase      = i2cbr_pkg::PH_IDLE;
            nxt_o.delay_left = '0;
            nxt_o.scl_drv    = 1'b1;
            nxt_o.sda_drv    = 1'b1;
            if (scl_i && sda_i) begin
              nxt_o.ok_cnt  = cur_i.ok_cnt + 1'b1;
              nxt_o.ok_flag = 1'b1;
              nxt_o.err     = i2cbr_pkg::ERR_NONE;
            end else begin
              nxt_o.fail_cnt = cur_i.fail_cnt + 1'b1;
              nxt_o.ok_flag  = 1'b0;
              nxt_o.err      = i2cbr_pkg::ERR_TIMEOUT;
            end
          end
          default: begin
            nxt_o.phase      = i2cbr_pkg::PH_IDLE;
            nxt_o.delay_left = '0;
          end
        endcase
      end
    end
  end

endmodule

FILE: design/i2c_bus_recovery_sequencer.sv
// data path: an accepted beat is held in the input register, stepped into the state and
//   result registers once the result side can take it, and shown on the result channel from then on
// throughput: one beat per cycle while the result channel is not stalled; the sequencer step
//   is one pass of logic between the input register and the result register
// reset: asynchronous, active low; config returns to 5 / 500 / 9, sequencer idle,
//   both lines released, counters zero, no beat held
module i2c_bus_recovery_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cbr_in_if.sink    in_i,
  i2cbr_out_if.source out_o,
  i2cbr_cfg_if.sink   cfg_i
);

  i2cbr_pkg::cfg_t   cfg_q;
  i2cbr_pkg::state_t state_q;
  i2cbr_pkg::state_t state_d;
  logic              step_done;

  logic in_valid_q;
  logic op_q;
  logic scl_q;
  logic sda_q;
  logic out_valid_q;
  logic done_q;
  logic advance;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period     <= i2cbr_pkg::HALF_RESET;
      cfg_q.stretch_timeout <= i2cbr_pkg::TOUT_RESET;
      cfg_q.pulse_count     <= i2cbr_pkg::PULSES_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        i2cbr_pkg::REG_HALF_PERIOD: cfg_q.half_period <= cfg_i.data[i2cbr_pkg::HalfW-1:0];
        i2cbr_pkg::REG_STRETCH_TO:  cfg_q.stretch_timeout <= cfg_i.data;
        i2cbr_pkg::REG_PULSE_COUNT: cfg_q.pulse_count <= cfg_i.data[i2cbr_pkg::PulseW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q  <= in_i.op;
      scl_q <= in_i.scl_in;
      sda_q <= in_i.sda_in;
    end
  end

  i2cbr_step u_step (
    .cur_i  (state_q),
    .cfg_i  (cfg_q),
    .op_i   (op_q),
    .scl_i  (scl_q),
    .sda_i  (sda_q),
    .nxt_o  (state_d),
    .done_o (step_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= i2cbr_pkg::PH_IDLE;
      state_q.delay_left     <= '0;
      state_q.stretch_waited <= '0;
      state_q.pulse_index    <= '0;
      state_q.scl_drv        <= 1'b1;
      state_q.sda_drv        <= 1'b1;
      state_q.rec_scl        <= 1'b0;
      state_q.rec_sda        <= 1'b0;
      state_q.ok_flag        <= 1'b0;
      state_q.err            <= i2cbr_pkg::ERR_NONE;
      state_q.ok_cnt         <= '0;
      state_q.fail_cnt       <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      done_q <= step_done;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.scl_release   = state_q.scl_drv;
  assign out_o.sda_release   = state_q.sda_drv;
  assign out_o.busy_res      = state_q.phase != i2cbr_pkg::PH_IDLE;
  assign out_o.done_res      = done_q;
  assign out_o.success       = state_q.ok_flag;
  assign out_o.seen_scl      = state_q.rec_scl;
  assign out_o.seen_sda      = state_q.rec_sda;
  assign out_o.timeout_err   = state_q.err;
  assign out_o.recover_total = state_q.ok_cnt;
  assign out_o.fail_total    = state_q.fail_cnt;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> state_q.phase == i2cbr_pkg::PH_IDLE)
    else $error("done beat with sequencer still busy");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == i2cbr_pkg::PH_IDLE |-> state_q.scl_drv && state_q.sda_drv)
    else $error("line driven low while idle");

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a blocked result");

  a_one_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> !(state_q.ok_cnt != $past(state_q.ok_cnt)
                  && state_q.fail_cnt != $past(state_q.fail_cnt)))
    else $error("both recovery counters moved on one beat");

endmodule

FILE: tb/i2c_bus_recovery_sequencer_test.sv
`timescale 1ns / 100ps
module i2c_bus_recovery_sequencer_test;
  import i2cbr_pkg::*;

  localparam int unsigned LongHold    = 250;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned MixBeats    = 400;
  localparam int unsigned TailBeats   = 250;

  typedef enum logic [1:0] {STRETCH_WAIT, STRETCH_CLEAR, STRETCH_EXPIRED} stretch_e;
  typedef enum logic [2:0] {
    BUS_CLEAN, BUS_STRETCH, BUS_SCL_STUCK, BUS_SDA_STUCK, BUS_NOISE
  } bus_mode_e;

  typedef struct packed {
    logic            scl_release;
    logic            sda_release;
    logic            busy;
    logic            done;
    logic            success;
    logic            seen_scl;
    logic            seen_sda;
    logic            timeout_err;
    logic [CntW-1:0] recover_total;
    logic [CntW-1:0] fail_total;
  } line_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  i2cbr_in_if  in_bus();
  i2cbr_out_if out_bus();
  i2cbr_cfg_if cfg_bus();

  i2c_bus_recovery_sequencer dut (
    .clk_i,
    .rst_ni,
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  cfg_t         seq_cfg;
  state_t       seq;
  logic         seq_done;
  line_status_t expected_status_q[$];

  int unsigned fault_count = 0;
  int unsigned results_seen = 0;
  int unsigned beats_sent = 0;
  int unsigned stretch_left = 0;
  int unsigned sda_hold_pulses = 0;
  bit          idling = 1'b1;
  bit          tail_quiet = 1'b0;
  bit          hold_request = 1'b0;
  bit          beat_offered = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // bus recovery predictor

  function automatic logic [DelayW-1:0] half_ticks();
    return (seq_cfg.half_period == '0) ? DelayW'(1) : DelayW'(seq_cfg.half_period);
  endfunction

  function automatic logic [DelayW-1:0] period_ticks();
    return half_ticks() << 1;
  endfunction

  function automatic void goto_phase(logic [PhaseW-1:0] ph, logic [DelayW-1:0] ticks);
    seq.phase = ph;
    seq.delay_left = ticks;
  endfunction

  function automatic stretch_e poll_scl(logic scl);
    if (scl) return STRETCH_CLEAR;
    if (seq.stretch_waited >= WaitW'(seq_cfg.stretch_timeout)) return STRETCH_EXPIRED;
    seq.stretch_waited = seq.stretch_waited + WaitW'(period_ticks());
    seq.delay_left = period_ticks();
    return STRETCH_WAIT;
  endfunction

  function automatic void close_recovery(logic good);
    if (good) begin
      seq.ok_cnt = seq.ok_cnt + 1'b1;
      seq.ok_flag = 1'b1;
      seq.err = ERR_NONE;
    end else begin
      seq.fail_cnt = seq.fail_cnt + 1'b1;
      seq.ok_flag = 1'b0;
      seq.err = ERR_TIMEOUT;
    end
    goto_phase(PH_IDLE, '0);
    seq.scl_drv = 1'b1;
    seq.sda_drv = 1'b1;
    seq_done = 1'b1;
  endfunction

  function automatic void begin_stop();
    seq.scl_drv = 1'b0;
    goto_phase(PH_STOP_A, half_ticks());
  endfunction

  function automatic void start_pulse();
    seq.scl_drv = 1'b0;
    goto_phase(PH_LOW, half_ticks());
  endfunction

  function automatic void next_pulse_or_stop(logic scl);
    stretch_e r;
    if (seq.pulse_index >= seq_cfg.pulse_count) begin
      begin_stop();
    end else begin
      seq.stretch_waited = '0;
      r = poll_scl(scl);
      if (r == STRETCH_CLEAR) start_pulse();
      else if (r == STRETCH_EXPIRED) begin_stop();
      else seq.phase = PH_PRE_WAIT;
    end
  endfunction

  function automatic void finish_delay(logic scl, logic sda);
    stretch_e r;
    case (seq.phase)
      PH_SETTLE: begin
        seq.rec_scl = scl;
        seq.rec_sda = sda;
        seq.stretch_waited = '0;
        r = poll_scl(scl);
        if (r == STRETCH_CLEAR) next_pulse_or_stop(scl);
        else if (r == STRETCH_EXPIRED) close_recovery(1'b0);
        else seq.phase = PH_INIT_WAIT;
      end
      PH_INIT_WAIT: begin
        r = poll_scl(scl);
        if (r == STRETCH_CLEAR) next_pulse_or_stop(scl);
        else if (r == STRETCH_EXPIRED) close_recovery(1'b0);
      end
      PH_PRE_WAIT: begin
        r = poll_scl(scl);
        if (r == STRETCH_CLEAR) start_pulse();
        else if (r == STRETCH_EXPIRED) begin_stop();
      end
      PH_LOW: begin
        seq.scl_drv = 1'b1;
        seq.stretch_waited = '0;
        goto_phase(PH_HIGH_WAIT, DelayW'(1));
      end
      PH_HIGH_WAIT: begin
        r = poll_scl(scl);
        if (r == STRETCH_CLEAR) goto_phase(PH_HIGH, half_ticks());
        else if (r == STRETCH_EXPIRED) begin_stop();
      end
      PH_HIGH: begin
        seq.pulse_index = seq.pulse_index + 1'b1;
        next_pulse_or_stop(scl);
      end
      PH_STOP_A: begin
        seq.sda_drv = 1'b0;
        goto_phase(PH_STOP_B, half_ticks());
      end
      PH_STOP_B: begin
        seq.scl_drv = 1'b1;
        seq.stretch_waited = '0;
        goto_phase(PH_STOP_WAIT, DelayW'(1));
      end
      PH_STOP_WAIT: begin
        r = poll_scl(scl);
        if (r != STRETCH_WAIT) goto_phase(PH_STOP_C, half_ticks());
      end
      PH_STOP_C: begin
        seq.sda_drv = 1'b1;
        goto_phase(PH_STOP_D, half_ticks());
      end
      PH_STOP_D: goto_phase(PH_FINAL, period_ticks());
      PH_FINAL: begin
        seq.rec_scl = scl;
        seq.rec_sda = sda;
        close_recovery(scl && sda);
      end
      default: goto_phase(PH_IDLE, '0);
    endcase
  endfunction

  function automatic line_status_t predict_status(logic op, logic scl, logic sda);
    line_status_t st;
    seq_done = 1'b0;
    if (op == OP_START) begin
      if (seq.phase == PH_IDLE) begin
        seq.scl_drv = 1'b1;
        seq.sda_drv = 1'b1;
        seq.stretch_waited = '0;
        seq.pulse_index = '0;
        goto_phase(PH_SETTLE, period_ticks());
      end
    end else if (seq.phase != PH_IDLE) begin
      if (seq.delay_left != '0) seq.delay_left = seq.delay_left - 1'b1;
      if (seq.delay_left == '0) finish_delay(scl, sda);
    end
    st.scl_release = seq.scl_drv;
    st.sda_release = seq.sda_drv;
    st.busy = (seq.phase != PH_IDLE);
    st.done = seq_done;
    st.success = seq.ok_flag;
    st.seen_scl = seq.rec_scl;
    st.seen_sda = seq.rec_sda;
    st.timeout_err = seq.err;
    st.recover_total = seq.ok_cnt;
    st.fail_total = seq.fail_cnt;
    return st;
  endfunction

  // checking

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= MaxReports) $display("result %0d: %s", results_seen, msg);
  endfunction

  function automatic void check_field(string name, logic [CntW-1:0] want, logic [CntW-1:0] got);
    if (got !== want) note_fault($sformatf("%s expected %0d, got %0d", name, want, got));
  endfunction

  function automatic void check_bit(string name, logic want, logic got);
    if (got !== want) note_fault($sformatf("%s expected %0b, got %0b", name, want, got));
  endfunction

  always @(posedge clk_i) begin
    line_status_t want;
    if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      results_seen++;
      if (expected_status_q.size() == 0) begin
        note_fault("result beat with nothing expected");
      end else begin
        want = expected_status_q.pop_front();
        check_bit("scl_release", want.scl_release, out_bus.scl_release);
        check_bit("sda_release", want.sda_release, out_bus.sda_release);
        check_bit("busy_res", want.busy, out_bus.busy_res);
        check_bit("done_res", want.done, out_bus.done_res);
        check_bit("success", want.success, out_bus.success);
        check_bit("seen_scl", want.seen_scl, out_bus.seen_scl);
        check_bit("seen_sda", want.seen_sda, out_bus.seen_sda);
        check_bit("timeout_err", want.timeout_err, out_bus.timeout_err);
        check_field("recover_total", want.recover_total, out_bus.recover_total);
        check_field("fail_total", want.fail_total, out_bus.fail_total);
      end
    end
  end

  // result side ready with random stalls and one long hold

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LongHold;
      end else if (hold_left == 0 && idling && !tail_quiet && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 6);
      end
      out_bus.ready <= (hold_left == 0);
      if (hold_left != 0) hold_left--;
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
          || (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // stimulus

  task automatic send_beat(logic op, logic scl, logic sda);
    int unsigned gap;
    gap = 0;
    if (idling && !tail_quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
    if (gap != 0 && beat_offered) begin
      in_bus.valid <= 1'b0;
      beat_offered = 1'b0;
    end
    repeat (gap) @(posedge clk_i);
    if (!beat_offered) begin
      in_bus.valid <= 1'b1;
      beat_offered = 1'b1;
    end
    in_bus.op <= op;
    in_bus.scl_in <= scl;
    in_bus.sda_in <= sda;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    expected_status_q.push_back(predict_status(op, scl, sda));
    beats_sent++;
  endtask

  task automatic drain_results();
    if (beat_offered) begin
      in_bus.valid <= 1'b0;
      beat_offered = 1'b0;
    end
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_HALF_PERIOD: seq_cfg.half_period = value[HalfW-1:0];
      REG_STRETCH_TO:  seq_cfg.stretch_timeout = value[ToutW-1:0];
      REG_PULSE_COUNT: seq_cfg.pulse_count = value[PulseW-1:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_setup(int unsigned half, int unsigned tout, int unsigned pulses);
    drain_results();
    write_reg(REG_HALF_PERIOD, CfgDataW'(half));
    write_reg(REG_STRETCH_TO, CfgDataW'(tout));
    write_reg(REG_PULSE_COUNT, CfgDataW'(pulses));
  endtask

  task automatic drive_tick(bus_mode_e mode);
    logic scl, sda;
    case (mode)
      BUS_SCL_STUCK: scl = 1'b0;
      BUS_NOISE: scl = 1'($urandom_range(0, 1));
      default: begin
        if (stretch_left != 0) begin
          scl = 1'b0;
          stretch_left--;
        end else if (!seq.scl_drv) begin
          scl = ($urandom_range(0, 9) == 0);
        end else begin
          scl = 1'b1;
          if (mode == BUS_STRETCH && $urandom_range(0, 11) == 0)
            stretch_left = $urandom_range(1, 3 * period_ticks());
        end
      end
    endcase
    if (mode == BUS_NOISE) sda = 1'($urandom_range(0, 1));
    else if (!seq.sda_drv || seq.pulse_index < sda_hold_pulses) sda = 1'b0;
    else sda = ($urandom_range(0, 15) != 0);
    send_beat(OP_TICK, scl, sda);
  endtask

  task automatic run_recovery(bus_mode_e mode);
    stretch_left = 0;
    sda_hold_pulses = (mode == BUS_SDA_STUCK) ? $urandom_range(1, 16) : $urandom_range(0, 2);
    send_beat(OP_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    while (seq.phase != PH_IDLE) begin
      if ($urandom_range(0, 39) == 0)
        send_beat(OP_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        drive_tick(mode);
    end
    repeat ($urandom_range(0, 2)) drive_tick(BUS_NOISE);
  endtask

  function automatic bus_mode_e pick_mode();
    bus_mode_e m;
    m = bus_mode_e'($urandom_range(0, 4));
    if (m == BUS_SCL_STUCK && seq_cfg.stretch_timeout > 300) m = BUS_STRETCH;
    return m;
  endfunction

  task automatic test_reset_defaults();
    send_beat(OP_TICK, 1'b0, 1'b0);
    send_beat(OP_TICK, 1'b0, 1'b1);
    send_beat(OP_TICK, 1'b1, 1'b0);
    send_beat(OP_TICK, 1'b1, 1'b1);
    run_recovery(BUS_CLEAN);
  endtask

  task automatic test_stuck_first_sample();
    load_setup(0, 0, 9);
    send_beat(OP_START, 1'b1, 1'b1);
    send_beat(OP_TICK, 1'b0, 1'b1);
    send_beat(OP_START, 1'b1, 1'b0);
    send_beat(OP_TICK, 1'b0, 1'b0);
    send_beat(OP_TICK, 1'b1, 1'b1);
  endtask

  task automatic test_no_pulses();
    load_setup(1, 0, 0);
    run_recovery(BUS_CLEAN);
    run_recovery(BUS_SDA_STUCK);
  endtask

  task automatic test_widest_period();
    load_setup(255, 0, 1);
    run_recovery(BUS_SCL_STUCK);
  endtask

  task automatic test_most_pulses();
    load_setup(1, 65535, 15);
    run_recovery(BUS_CLEAN);
    run_recovery(BUS_STRETCH);
  endtask

  task automatic test_backpressure();
    load_setup(2, 20, 15);
    idling = 1'b0;
    hold_request = 1'b1;
    run_recovery(BUS_STRETCH);
    run_recovery(BUS_CLEAN);
    idling = 1'b1;
  endtask

  task automatic test_random_mix();
    int unsigned stop_at, half, tout, r;
    stop_at = beats_sent + MixBeats;
    while (beats_sent < stop_at) begin
      r = $urandom_range(0, 9);
      half = (r == 0) ? 0 : (r < 7) ? $urandom_range(1, 3) : $urandom_range(4, 8);
      r = $urandom_range(0, 9);
      tout = (r == 0) ? 0 : (r < 6) ? $urandom_range(1, 40)
           : (r < 9) ? $urandom_range(41, 400) : $urandom_range(401, 65535);
      load_setup(half, tout, $urandom_range(0, 15));
      idling = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) run_recovery(pick_mode());
    end
    idling = 1'b1;
  endtask

  task automatic test_no_idling_tail();
    int unsigned stop_at;
    load_setup(5, 500, 9);
    tail_quiet = 1'b1;
    stop_at = beats_sent + TailBeats;
    while (beats_sent < stop_at) run_recovery(pick_mode());
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.op = OP_TICK;
    in_bus.scl_in = 1'b1;
    in_bus.sda_in = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_HALF_PERIOD;
    cfg_bus.data = '0;
    seq_cfg.half_period = HALF_RESET;
    seq_cfg.stretch_timeout = TOUT_RESET;
    seq_cfg.pulse_count = PULSES_RESET;
    seq = '0;
    seq.phase = PH_IDLE;
    seq.scl_drv = 1'b1;
    seq.sda_drv = 1'b1;
    seq.err = ERR_NONE;
    seq_done = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_stuck_first_sample();
    test_no_pulses();
    test_widest_period();
    test_most_pulses();
    test_backpressure();
    test_random_mix();
    test_no_idling_tail();

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (expected_status_q.size() != 0) note_fault("expected results never arrived");
    if (fault_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/i2cbr_pkg.sv
design/i2cbr_if.sv
design/i2cbr_step.sv
design/i2c_bus_recovery_sequencer.sv
tb/i2c_bus_recovery_sequencer_test.sv
